/* rtl/swkr_pkg.sv */
// Package for the keyed-removal stack: sizes, command and status codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package swkr_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int KEY_W = 64;
   localparam int TAG_W = 64;
   localparam int OCC_W = 5;

   typedef enum logic [1:0] {
      CMD_PUSH   = 2'd0,
      CMD_POP    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_LIST   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_EMPTY    = 2'd1,
      STAT_NOTFOUND = 2'd2,
      STAT_FULL     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_RESP
   } state_type;

   typedef enum logic [2:0] {
      SEL_ZERO,
      SEL_REQ,
      SEL_TOP,
      SEL_MATCH,
      SEL_LIST
   } out_sel_type;

   typedef struct packed {
      logic        capture;
      logic        load_out;
      out_sel_type out_sel;
      status_type  out_status;
      logic        do_push;
      logic        do_pop;
      logic        do_remove;
      logic        list_start;
      logic        list_next;
   } dp_ctrl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    empty;
      logic    full;
      logic    found;
      logic    list_more;
   } dp_stat_type;

endpackage

/* rtl/swkr_ctrl.sv */
// Controller state machine of the keyed-removal stack: handshakes and
// per-command sequencing. Depends on swkr_pkg.
module swkr_ctrl
   import swkr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_ctrl_type ctrl
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready && !stat.list_more) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready       = 1'b0;
      rsp_valid       = 1'b0;
      ctrl            = '0;
      ctrl.out_sel    = SEL_ZERO;
      ctrl.out_status = STAT_OK;
      case (state_ff)
         S_IDLE: begin
            req_ready    = 1'b1;
            ctrl.capture = req_valid;
         end
         S_EXEC: begin
            ctrl.load_out = 1'b1;
            case (stat.cmd)
               CMD_PUSH: begin
                  if (stat.full) begin
                     ctrl.out_status = STAT_FULL;
                  end else begin
                     ctrl.do_push = 1'b1;
                     ctrl.out_sel = SEL_REQ;
                  end
               end
               CMD_POP: begin
                  if (stat.empty) begin
                     ctrl.out_status = STAT_EMPTY;
                  end else begin
                     ctrl.do_pop  = 1'b1;
                     ctrl.out_sel = SEL_TOP;
                  end
               end
               CMD_REMOVE: begin
                  if (stat.empty) begin
                     ctrl.out_status = STAT_EMPTY;
                  end else if (!stat.found) begin
                     ctrl.out_status = STAT_NOTFOUND;
                  end else begin
                     ctrl.do_remove = 1'b1;
                     ctrl.out_sel   = SEL_MATCH;
                  end
               end
               CMD_LIST: begin
                  if (stat.empty) begin
                     ctrl.out_status = STAT_EMPTY;
                  end else begin
                     ctrl.list_start = 1'b1;
                     ctrl.out_sel    = SEL_LIST;
                  end
               end
               default: begin
                  ctrl.out_status = STAT_EMPTY;
               end
            endcase
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready && stat.list_more) begin
               ctrl.load_out  = 1'b1;
               ctrl.list_next = 1'b1;
               ctrl.out_sel   = SEL_LIST;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

/* rtl/swkr_datapath.sv */
// Datapath of the keyed-removal stack: entry cells with parallel key compare
// and gap-closing shift, count, list pointer and result register. Depends on swkr_pkg.
module swkr_datapath
   import swkr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  dp_ctrl_type        ctrl,
   output dp_stat_type        stat,
   input  logic [1:0]         req_command,
   input  logic [KEY_W-1:0]   req_key_in,
   input  logic [TAG_W-1:0]   req_tag_in,
   output logic [1:0]         rsp_status,
   output logic [KEY_W-1:0]   rsp_key_out,
   output logic [TAG_W-1:0]   rsp_tag_out,
   output logic [OCC_W-1:0]   rsp_occupancy,
   output logic               rsp_last
);

   logic [KEY_W-1:0] ent_key_ff [DEPTH];
   logic [KEY_W-1:0] ent_key_in [DEPTH];
   logic [TAG_W-1:0] ent_tag_ff [DEPTH];
   logic [TAG_W-1:0] ent_tag_in [DEPTH];

   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   cmd_type          cmd_ff;
   logic [KEY_W-1:0] key_req_ff;
   logic [TAG_W-1:0] tag_req_ff;

   status_type       out_status_ff, out_status_in;
   logic [KEY_W-1:0] out_key_ff, out_key_in;
   logic [TAG_W-1:0] out_tag_ff, out_tag_in;
   logic [CNT_W-1:0] out_occ_ff, out_occ_in;
   logic             out_last_ff, out_last_in;

   logic [DEPTH-1:0] hit;
   logic [DEPTH-1:0] at_or_above;
   logic [DEPTH-1:0] first_hit;
   logic [KEY_W-1:0] match_key;
   logic [TAG_W-1:0] match_tag;
   logic [CNT_W-1:0] cnt_m1;
   logic [IDX_W-1:0] rd_idx;
   logic [IDX_W-1:0] idx_m1;
   logic [CNT_W+OCC_W-1:0] occ_ext;

   // hold the request
   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff     <= cmd_type'(req_command);
         key_req_ff <= req_key_in;
         tag_req_ff <= req_tag_in;
      end
   end

   // compare every live cell at once, find the bottom-most hit
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         hit[i] = (CNT_W'(i) < count_ff) && (ent_key_ff[i] == key_req_ff);
      end
      at_or_above[0] = hit[0];
      for (int i = 1; i < DEPTH; i++) begin
         at_or_above[i] = at_or_above[i-1] | hit[i];
      end
      first_hit[0] = hit[0];
      for (int i = 1; i < DEPTH; i++) begin
         first_hit[i] = hit[i] & ~at_or_above[i-1];
      end
      match_key = '0;
      match_tag = '0;
      for (int i = 0; i < DEPTH; i++) begin
         match_key = match_key | ({KEY_W{first_hit[i]}} & ent_key_ff[i]);
         match_tag = match_tag | ({TAG_W{first_hit[i]}} & ent_tag_ff[i]);
      end
   end

   assign cnt_m1 = count_ff - CNT_W'(1);
   assign idx_m1 = idx_ff - IDX_W'(1);
   assign rd_idx = ctrl.list_next ? idx_m1 : cnt_m1[IDX_W-1:0];

   // cell update: push writes the top, remove shifts down from the hit
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ent_key_in[i] = ent_key_ff[i];
         ent_tag_in[i] = ent_tag_ff[i];
      end
      if (ctrl.do_push) begin
         ent_key_in[count_ff[IDX_W-1:0]] = key_req_ff;
         ent_tag_in[count_ff[IDX_W-1:0]] = tag_req_ff;
      end
      if (ctrl.do_remove) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            if (at_or_above[i]) begin
               ent_key_in[i] = ent_key_ff[i+1];
               ent_tag_in[i] = ent_tag_ff[i+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         ent_key_ff[i] <= ent_key_in[i];
         ent_tag_ff[i] <= ent_tag_in[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.do_push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.do_pop || ctrl.do_remove) begin
         count_in = cnt_m1;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (ctrl.list_start) begin
         idx_in = cnt_m1[IDX_W-1:0];
      end else if (ctrl.list_next) begin
         idx_in = idx_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   // result register
   always_comb begin
      out_status_in = ctrl.out_status;
      out_occ_in    = count_in;
      out_last_in   = 1'b1;
      out_key_in    = '0;
      out_tag_in    = '0;
      case (ctrl.out_sel)
         SEL_ZERO: begin
            out_key_in = '0;
         end
         SEL_REQ: begin
            out_key_in = key_req_ff;
            out_tag_in = tag_req_ff;
         end
         SEL_TOP: begin
            out_key_in = ent_key_ff[rd_idx];
            out_tag_in = ent_tag_ff[rd_idx];
         end
         SEL_MATCH: begin
            out_key_in = match_key;
            out_tag_in = match_tag;
         end
         SEL_LIST: begin
            out_key_in  = ent_key_ff[rd_idx];
            out_tag_in  = ent_tag_ff[rd_idx];
            out_last_in = (rd_idx == '0);
         end
         default: begin
            out_key_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_out) begin
         out_status_ff <= out_status_in;
         out_key_ff    <= out_key_in;
         out_tag_ff    <= out_tag_in;
         out_occ_ff    <= out_occ_in;
         out_last_ff   <= out_last_in;
      end
   end

   assign occ_ext = {{OCC_W{1'b0}}, out_occ_ff};

   assign rsp_status    = out_status_ff;
   assign rsp_key_out   = out_key_ff;
   assign rsp_tag_out   = out_tag_ff;
   assign rsp_occupancy = occ_ext[OCC_W-1:0];
   assign rsp_last      = out_last_ff;

   assign stat.cmd       = cmd_ff;
   assign stat.empty     = (count_ff == '0);
   assign stat.full      = (count_ff >= CNT_W'(DEPTH));
   assign stat.found     = at_or_above[DEPTH-1];
   assign stat.list_more = !out_last_ff;

endmodule

/* rtl/stack_with_keyed_removal.sv */
// Top level of the keyed-removal stack: joins the controller and the datapath.
// Depends on swkr_pkg, swkr_ctrl and swkr_datapath.
//
//  channel | ports                                   | moves
//  --------+-----------------------------------------+------------------------------
//  req     | req_valid/req_ready, command, key, tag  | one command per transaction
//  rsp     | rsp_valid/rsp_ready, status, key, tag,  | one or more results per
//          | occupancy, last                         | command, last on the final one
//
// Sequence: a command is accepted while idle, executes in the next cycle, and its
// first result is valid in the cycle after that. Each further list entry follows
// in the cycle after the previous result is taken. The next command is accepted in
// the cycle after the final result is taken. All keys are compared in parallel, and
// removal closes the gap within the execute cycle. Reset clears the entry count and
// the controller; entry contents are left as is. A stalled result holds in the
// output register, and req_ready stays low until the final result of the current
// command is taken.
module stack_with_keyed_removal
   import swkr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_command,
   input  logic [KEY_W-1:0] req_key_in,
   input  logic [TAG_W-1:0] req_tag_in,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [KEY_W-1:0] rsp_key_out,
   output logic [TAG_W-1:0] rsp_tag_out,
   output logic [OCC_W-1:0] rsp_occupancy,
   output logic             rsp_last
);

   dp_ctrl_type ctrl;
   dp_stat_type stat;

   // sequence each transaction
   swkr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   // hold the entries and the result register
   swkr_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .stat          (stat),
      .req_command   (req_command),
      .req_key_in    (req_key_in),
      .req_tag_in    (req_tag_in),
      .rsp_status    (rsp_status),
      .rsp_key_out   (rsp_key_out),
      .rsp_tag_out   (rsp_tag_out),
      .rsp_occupancy (rsp_occupancy),
      .rsp_last      (rsp_last)
   );

endmodule
